### rtl/core/mbp_pkg.sv
package mbp_pkg;

    // Fixed geometry of the packed output
    localparam int WORD_BITS   = 32;
    localparam int BYTE_BITS   = 8;
    localparam int WORD_BYTES  = WORD_BITS / BYTE_BITS;
    localparam int FILL_W      = $clog2(WORD_BITS);
    localparam int SHIFT_W     = FILL_W + 1;
    localparam int LEN_W       = 11;
    localparam int COUNT_W     = 3;
    localparam int CMD_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_ZERO  = 2'd1,
        CMD_PAD   = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_ZERO,
        OP_PAD,
        OP_FLUSH,
        OP_ERROR
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [WORD_BITS-1:0]   bits;   // write bits, left-aligned
        logic [LEN_W-1:0]       len;
    } t_op;

    // Queue handshake between front and back
    typedef struct packed {
        logic push;
        t_op  op;
    } t_q_push;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

endpackage

### rtl/core/mbp_front.sv
module mbp_front
    import mbp_pkg::*;
(
    input  logic                 i_valid,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [LEN_W-1:0]     i_length,
    input  logic                 i_q_full,
    output logic                 o_stall,
    output t_q_push              o_q_push
);

    logic [SHIFT_W-1:0] align_amt;
    t_op                op;

    // Left-align the write bits; bits above the length fall off the top
    assign align_amt = SHIFT_W'(WORD_BITS) - i_length[SHIFT_W-1:0];

    // Classify the incoming word
    always_comb begin
        op.kind = OP_FLUSH;
        op.bits = '0;
        op.len  = i_length;
        unique case (t_cmd'(i_command))
            CMD_WRITE: begin
                if (i_length > LEN_W'(WORD_BITS)) begin
                    op.kind = OP_ERROR;
                end else begin
                    op.kind = OP_APPEND;
                    op.bits = i_value << align_amt;
                end
            end
            CMD_ZERO:  op.kind = OP_ZERO;
            CMD_PAD:   op.kind = OP_PAD;
            default:   op.kind = OP_FLUSH;
        endcase
    end

    assign o_stall       = i_q_full;
    assign o_q_push.push = i_valid && !i_q_full;
    assign o_q_push.op   = op;

endmodule

### rtl/core/mbp_queue.sv
module mbp_queue
    import mbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_slot[r_rd_ptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Store the pushed operation
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/mbp_back.sv
module mbp_back
    import mbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_head              i_head,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_word,
    output logic [COUNT_W-1:0]   o_byte_count,
    output logic                 o_length_error,
    output logic                 o_last
);

    logic [WORD_BITS-1:0]   r_pw, n_pw;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [LEN_W-1:0]       r_remain;
    logic                   r_started;
    logic                   r_out_valid;
    logic [WORD_BITS-1:0]   r_out_word;
    logic [COUNT_W-1:0]     r_out_count;
    logic                   r_out_err;
    logic                   r_out_last;

    logic                   out_free, step;
    logic [LEN_W-1:0]       eff_len, new_rem;
    logic [SHIFT_W-1:0]     step_len, tot;
    logic [WORD_BITS-1:0]   step_bits;
    logic [2*WORD_BITS-1:0] cat;
    logic [1:0]             nbytes;
    logic [SHIFT_W-1:0]     flush_sh;
    logic                   emit;
    logic [WORD_BITS-1:0]   emit_word;
    logic [COUNT_W-1:0]     emit_count;
    logic                   emit_err;
    logic                   emit_last;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = i_head.valid && out_free;
    assign eff_len  = r_started ? r_remain : i_head.op.len;
    assign nbytes   = r_fill[FILL_W-1:3];
    assign flush_sh = {1'b0, nbytes, 3'b000};

    // Pick the chunk this step appends
    always_comb begin
        step_len  = '0;
        step_bits = '0;
        new_rem   = '0;
        case (i_head.op.kind)
            OP_APPEND: begin
                step_len  = i_head.op.len[SHIFT_W-1:0];
                step_bits = i_head.op.bits;
            end
            OP_ZERO: begin
                if (eff_len > LEN_W'(WORD_BITS)) begin
                    step_len = SHIFT_W'(WORD_BITS);
                end else begin
                    step_len = eff_len[SHIFT_W-1:0];
                end
                new_rem = eff_len - LEN_W'(step_len);
            end
            OP_PAD: begin
                if (r_fill[2:0] != 3'd0) begin
                    step_len = SHIFT_W'(BYTE_BITS) - SHIFT_W'(r_fill[2:0]);
                end
            end
            default: ;
        endcase
    end

    // Merge the chunk under the held bits
    assign cat = {r_pw, {WORD_BITS{1'b0}}}
               | ({step_bits, {WORD_BITS{1'b0}}} >> r_fill);
    assign tot = SHIFT_W'(r_fill) + step_len;

    // Work out the next state and the result of this step
    always_comb begin
        n_pw       = r_pw;
        n_fill     = r_fill;
        emit       = 1'b0;
        emit_word  = cat[2*WORD_BITS-1:WORD_BITS];
        emit_count = COUNT_W'(WORD_BYTES);
        emit_err   = 1'b0;
        case (i_head.op.kind)
            OP_FLUSH: begin
                emit       = (nbytes != 2'd0);
                emit_word  = r_pw & ~({WORD_BITS{1'b1}} >> flush_sh);
                emit_count = COUNT_W'(nbytes);
                n_pw       = r_pw << flush_sh;
                n_fill     = FILL_W'(r_fill[2:0]);
            end
            OP_ERROR: begin
                emit       = 1'b1;
                emit_word  = '0;
                emit_count = '0;
                emit_err   = 1'b1;
            end
            default: begin
                n_fill = tot[FILL_W-1:0];
                if (tot[SHIFT_W-1]) begin
                    emit = 1'b1;
                    n_pw = cat[WORD_BITS-1:0];
                end else begin
                    n_pw = cat[2*WORD_BITS-1:WORD_BITS];
                end
            end
        endcase
        // No later step of this operation will complete a word
        emit_last = ((LEN_W + 1)'(n_fill) + (LEN_W + 1)'(new_rem))
                  < (LEN_W + 1)'(WORD_BITS);
    end

    assign o_pop = step && (new_rem == '0);

    // Advance packer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw      <= '0;
            r_fill    <= '0;
            r_started <= 1'b0;
        end else if (step) begin
            r_pw      <= n_pw;
            r_fill    <= n_fill;
            r_started <= (new_rem != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_remain <= new_rem;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_word  <= emit_word;
            r_out_count <= emit_count;
            r_out_err   <= emit_err;
            r_out_last  <= emit_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_word         = r_out_word;
    assign o_byte_count   = r_out_count;
    assign o_length_error = r_out_err;
    assign o_last         = r_out_last;

endmodule

### rtl/core/msb_first_bit_packer_core.sv
// MSB-first bit packer. Each input word carries a command: write the low
// 0..32 bits of i_value, append a run of up to 2047 zero bits, pad with zeros
// to the next byte boundary, or flush the whole bytes held so far. Every
// 32-bit output word that fills up is sent at once with byte count 4; a flush
// sends one word with 1 to 3 leading bytes (none if no whole byte is held)
// and keeps the leftover bits. A write longer than 32 bits returns one word
// with o_length_error set and leaves the state alone. o_last marks the final
// output word of each input. Timing: the front decodes and aligns one input
// per cycle into a two-entry queue while it has room; the back packer retires
// one queue entry per cycle while the output is free, except a zero run, which
// it appends in chunks of up to 32 bits. Results pass through a queue slot and
// then a single output register, and o_stall rises when the queue is full.
module msb_first_bit_packer_core
    import mbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [LEN_W-1:0]     i_length,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_word,
    output logic [COUNT_W-1:0]   o_byte_count,
    output logic                 o_length_error,
    output logic                 o_last
);

    t_q_push q_push;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;

    mbp_front u_front (
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_value   (i_value),
        .i_length  (i_length),
        .i_q_full  (q_full),
        .o_stall   (o_stall),
        .o_q_push  (q_push)
    );

    mbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    mbp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_word         (o_word),
        .o_byte_count   (o_byte_count),
        .o_length_error (o_length_error),
        .o_last         (o_last)
    );

endmodule
